// File: sv/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants for the prefer-clean LRU replacement engine.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Fixed field widths of the stream payloads
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int SET_IDX_W  = 6;
  localparam int HIT_WAY_W  = 3;
  localparam int VICTIM_W   = 3;
  localparam int STAMP_W    = 32;

  // Item kinds carried in tuser
  localparam logic MODE_ACCESS = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } lpc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;     // write zero at the clear pointer
    logic access;       // access item taken this cycle
    logic query_start;  // query item taken this cycle
    logic scan_rd;      // read the next way of the query set
    logic out_load;     // load the result register
  } lpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;      // clear pointer at the last entry
    logic scan_last;       // way counter at the last way
    logic query_in_range;  // offered set index exists
    logic out_free;        // result register can take a new result
  } lpc_status_t;

endpackage

// File: sv/lpc_ctrl.sv
// ----------------------------------------------------------------------------
// lpc_ctrl
// Sequencer: clearing pass, item intake, way scan and result hand-off.
// ----------------------------------------------------------------------------
module lpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  input  lpc_pkg::lpc_status_t status,
  output lpc_pkg::lpc_cmd_t    cmd
);
  import lpc_pkg::*;

  lpc_state_t state;
  lpc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && (in_mode == MODE_QUERY)) begin
          state_next = status.query_in_range ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready         = 1'b0;
    cmd              = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.access      = in_valid && (in_mode == MODE_ACCESS);
        cmd.query_start = in_valid && (in_mode == MODE_QUERY);
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The scan covers every way: no early exit
  a_scan_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && !status.scan_last |=> (state == ST_SCAN))
    else $error("scan left before the last way");

  // A query moves on to the scan, or for a missing set straight to the result state
  a_query_to_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.query_start |=> (state == ST_SCAN) || (state == ST_EMIT))
    else $error("query not followed by scan or result");

  // Clearing pass completes before any item is taken
  a_no_intake_clearing: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !cmd.access && !cmd.query_start)
    else $error("item taken during clearing pass");
`endif

endmodule

// File: sv/lpc_datapath.sv
// ----------------------------------------------------------------------------
// lpc_datapath
// Stamp/dirty memory, access counter, per-way oldest search, result register.
// ----------------------------------------------------------------------------
module lpc_datapath #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lpc_pkg::SET_IDX_W-1:0]        in_set_index,
  input  logic                                in_hit_valid,
  input  logic [lpc_pkg::HIT_WAY_W-1:0]        in_hit_way,
  input  logic                                in_hit_modified,
  input  lpc_pkg::lpc_cmd_t                    cmd,
  output lpc_pkg::lpc_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lpc_pkg::VICTIM_W-1:0]         out_victim_way,
  output logic                                out_victim_found
);
  import lpc_pkg::*;

  localparam int DEPTH  = NUM_SETS * NUM_WAYS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  // Entry: {dirty, stamp}
  logic [STAMP_W:0]   mem [DEPTH];
  logic [STAMP_W:0]   rd_data;

  logic [STAMP_W-1:0] access_count;
  logic [STAMP_W-1:0] access_count_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [ADDR_W-1:0]  base;
  logic [WAY_W-1:0]   way_cnt;
  logic               cmp_en;
  logic [WAY_W-1:0]   cmp_way;

  logic               clean_ok;
  logic [STAMP_W-1:0] clean_best;
  logic [WAY_W-1:0]   clean_way;
  logic               dirty_ok;
  logic [STAMP_W-1:0] dirty_best;
  logic [WAY_W-1:0]   dirty_way;

  logic               set_ok;
  logic               way_ok;
  logic [ADDR_W-1:0]  set_first;
  logic [ADDR_W-1:0]  hit_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [STAMP_W:0]   wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_dirty;
  logic [STAMP_W-1:0] rd_stamp;
  logic [WAY_W-1:0]   sel_way;
  logic [WAY_W+2:0]   sel_way_ext;

  assign set_ok    = 32'(in_set_index) < 32'(NUM_SETS);
  assign way_ok    = 32'(in_hit_way) < 32'(NUM_WAYS);
  assign set_first = ADDR_W'(32'(in_set_index) * 32'(NUM_WAYS));
  assign hit_addr  = ADDR_W'(32'(in_set_index) * 32'(NUM_WAYS) + 32'(in_hit_way));

  assign access_count_next = access_count + 32'd1;

  // Single write port shared by the clearing pass and hit updates
  assign wr_en   = cmd.clear_wr || (cmd.access && in_hit_valid && set_ok && way_ok);
  assign wr_addr = cmd.clear_wr ? clr_addr : hit_addr;
  assign wr_data = cmd.clear_wr ? '0 : {in_hit_modified, access_count_next};
  assign rd_addr = base + ADDR_W'(way_cnt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign rd_dirty = rd_data[STAMP_W];
  assign rd_stamp = rd_data[STAMP_W-1:0];

  // Counter and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      access_count <= '0;
      clr_addr     <= '0;
      cmp_en       <= 1'b0;
    end else begin
      if (cmd.access) begin
        access_count <= access_count_next;
      end
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      cmp_en <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      base    <= set_first;
      way_cnt <= '0;
    end else if (cmd.scan_rd) begin
      way_cnt <= way_cnt + WAY_W'(1);
    end
    cmp_way <= way_cnt;
  end

  // Oldest clean and oldest dirty, strict compare keeps the lowest way on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      clean_ok <= 1'b0;
      dirty_ok <= 1'b0;
    end else if (cmd.query_start) begin
      clean_ok <= 1'b0;
      dirty_ok <= 1'b0;
    end else if (cmp_en) begin
      if (!rd_dirty && (rd_stamp < clean_best)) begin
        clean_ok <= 1'b1;
      end
      if (rd_dirty && (rd_stamp < dirty_best)) begin
        dirty_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      clean_best <= '1;
      dirty_best <= '1;
      clean_way  <= '0;
      dirty_way  <= '0;
    end else if (cmp_en) begin
      if (!rd_dirty && (rd_stamp < clean_best)) begin
        clean_best <= rd_stamp;
        clean_way  <= cmp_way;
      end
      if (rd_dirty && (rd_stamp < dirty_best)) begin
        dirty_best <= rd_stamp;
        dirty_way  <= cmp_way;
      end
    end
  end

  // Result register
  assign sel_way     = clean_ok ? clean_way : (dirty_ok ? dirty_way : '0);
  assign sel_way_ext = {3'b000, sel_way};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_victim_way   <= sel_way_ext[2:0];
      out_victim_found <= clean_ok || dirty_ok;
    end
  end

  always_comb begin
    status.clear_last     = (clr_addr == ADDR_W'(DEPTH - 1));
    status.scan_last      = (way_cnt == WAY_W'(NUM_WAYS - 1));
    status.query_in_range = set_ok;
    status.out_free       = !out_valid || out_ready;
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("pending result overwritten");

  a_clean_best: assert property (@(posedge clk) disable iff (rst)
    clean_ok |-> clean_best != '1)
    else $error("clean candidate with saturated stamp");

  a_dirty_best: assert property (@(posedge clk) disable iff (rst)
    dirty_ok |-> dirty_best != '1)
    else $error("dirty candidate with saturated stamp");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.access |=> access_count == $past(access_count) + 32'd1)
    else $error("access counter did not advance by one");
`endif

endmodule

// File: sv/lru_prefer_clean_replacement.sv
// ----------------------------------------------------------------------------
// lru_prefer_clean_replacement
// Replacement-policy engine for a set-associative cache: oldest clean line
// first, else oldest dirty line.
// ----------------------------------------------------------------------------
// Each line keeps a 32-bit access stamp and a dirty mark in one on-chip
// memory of NUM_SETS*NUM_WAYS entries; a global 32-bit access counter wraps.
// After reset the block runs a clearing pass over all NUM_SETS*NUM_WAYS
// entries, one entry a cycle, with s_axis_tready low. An access (tuser
// mode 0) advances the counter and, on a hit to an existing set and way,
// the line's stamp takes the new count and its dirty mark follows
// hit_modified (set or cleared). Accesses can stream back to back. An evict
// query (mode 1) runs through the intake, one memory read per way over the
// single read port, a compare of the last read, and the load of the result
// register. A query to a missing set skips the scan.
// A stamp of all ones never qualifies; ties go to the lowest way; with no
// candidate the result is way 0 with victim_found low. The result register
// holds a transfer until m_axis_tready takes it; a query that finishes
// while an earlier result still waits holds until the register is free.
// ----------------------------------------------------------------------------
module lru_prefer_clean_replacement #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] set_index, [6] hit_valid, [9:7] hit_way, [10] hit_modified, rest zero
  input  logic [lpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] mode
  input  logic [0:0]                        s_axis_tuser,
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] victim_way, [3] victim_found, rest zero
  output logic [lpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import lpc_pkg::*;

  lpc_cmd_t              cmd;
  lpc_status_t           status;
  logic [SET_IDX_W-1:0]  in_set_index;
  logic                  in_hit_valid;
  logic [HIT_WAY_W-1:0]  in_hit_way;
  logic                  in_hit_modified;
  logic [VICTIM_W-1:0]   victim_way;
  logic                  victim_found;

  // Payload unpacking
  assign in_set_index    = s_axis_tdata[5:0];
  assign in_hit_valid    = s_axis_tdata[6];
  assign in_hit_way      = s_axis_tdata[9:7];
  assign in_hit_modified = s_axis_tdata[10];

  lpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lpc_datapath #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .in_set_index     (in_set_index),
    .in_hit_valid     (in_hit_valid),
    .in_hit_way       (in_hit_way),
    .in_hit_modified  (in_hit_modified),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_victim_way   (victim_way),
    .out_victim_found (victim_found)
  );

  assign m_axis_tdata = {4'b0000, victim_found, victim_way};

endmodule
